@@ rtl/rrmv_pkg.sv @@
`default_nettype none

package rrmv_pkg;

	// sequencer states, one-hot
	typedef enum logic [14:0] {
		ST_IDLE = 15'b000000000000001,
		ST_SCRD = 15'b000000000000010,
		ST_SCCK = 15'b000000000000100,
		ST_NEXT = 15'b000000000001000,
		ST_RD   = 15'b000000000010000,
		ST_LOAD = 15'b000000000100000,
		ST_DLT  = 15'b000000001000000,
		ST_DIVW = 15'b000000010000000,
		ST_NM   = 15'b000000100000000,
		ST_MUL  = 15'b000001000000000,
		ST_M2   = 15'b000010000000000,
		ST_WR   = 15'b000100000000000,
		ST_VAR  = 15'b001000000000000,
		ST_VARW = 15'b010000000000000,
		ST_EMIT = 15'b100000000000000
	} state_t;

	localparam logic [1:0] CMD_UPDATE = 2'd0;
	localparam logic [1:0] CMD_RESET  = 2'd1;
	localparam logic [1:0] CMD_ADD    = 2'd2;
	localparam logic [1:0] CMD_NOP    = 2'd3;

	localparam logic [1:0] KIND_VAR    = 2'd0;
	localparam logic [1:0] KIND_REGION = 2'd1;
	localparam logic [1:0] KIND_ACK    = 2'd2;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_SAT  = 2'd2;

	localparam logic [6:0]  DIV_STEPS = 7'd64;
	localparam logic [37:0] VAR_MAX   = 38'h3F_FFFF_FFFF;

endpackage

`default_nettype wire

@@ rtl/region_running_mean_variance_unit.sv @@
`default_nettype none

// Welford running mean and variance of 2-D points for NUM_TRACKED variables, each with up to
// MAX_REGIONS inclusive boxes that keep statistics of their own. One item is worked at a time;
// in_stall stays high until its last result has been handed to the output register. Reset and
// add-region commands go straight to the emit state. An update scans the variable's boxes in
// use from the top slot down, then works its own accumulator and, in slot order, that of each
// hit region: read, load, two mean steps (delta, division by the count, new mean, product, M2
// update), write-back, two variance divisions and emit. A first sample skips the mean steps and
// the variance divisions; a saturated count skips the mean steps and write-back. One shared
// restoring divider does every division; a stalled output holds the emit state.
module region_running_mean_variance_unit #(
	parameter int NUM_TRACKED = 4,
	parameter int MAX_REGIONS = 4,
	parameter int COUNT_BITS  = 20
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic [1:0]         var_index,
	input  wire logic signed [14:0] point_x,
	input  wire logic signed [14:0] point_y,
	input  wire logic signed [14:0] box_min_x,
	input  wire logic signed [14:0] box_min_y,
	input  wire logic signed [14:0] box_max_x,
	input  wire logic signed [14:0] box_max_y,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              kind,
	output logic [1:0]              region_slot,
	output logic [1:0]              status,
	output logic [19:0]             sample_count,
	output logic signed [30:0]      mean_x,
	output logic signed [30:0]      mean_y,
	output logic [37:0]             variance_x,
	output logic [37:0]             variance_y,
	output logic                    last
);

	localparam int NUM_ACC = NUM_TRACKED + NUM_TRACKED * MAX_REGIONS;
	localparam int ACC_W   = $clog2(NUM_ACC);
	localparam int BOX_N   = NUM_TRACKED * MAX_REGIONS;
	localparam int BOX_W   = (BOX_N > 1) ? $clog2(BOX_N) : 1;
	localparam int V_W     = (NUM_TRACKED > 1) ? $clog2(NUM_TRACKED) : 1;
	localparam int RJ_W    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int RU_W    = $clog2(MAX_REGIONS + 1);
	localparam int CB      = COUNT_BITS;

	rrmv_pkg::state_t state_q;

	// control registers
	logic                   ax_q;
	logic                   is_reg_q;
	logic [RJ_W-1:0]        j_q;
	logic [RU_W-1:0]        sc_q;
	logic [MAX_REGIONS-1:0] pend_q;
	logic [RU_W-1:0]        ru_q [NUM_TRACKED];
	logic [NUM_ACC-1:0]     acc_vld_q;
	logic [NUM_ACC-1:0]     vld_d;
	logic                   out_valid_q;
	logic                   div_busy_q;
	logic [6:0]             div_cnt_q;

	// working registers
	logic [V_W-1:0]         v_q;
	logic signed [14:0]     px_q;
	logic signed [14:0]     py_q;
	logic [1:0]             wkind_q;
	logic [1:0]             wslot_q;
	logic [1:0]             wstat_q;
	logic [CB-1:0]          cnt_q;
	logic signed [31:0]     mx_q;
	logic signed [31:0]     my_q;
	logic [63:0]            m2x_q;
	logic [63:0]            m2y_q;
	logic [37:0]            varx_q;
	logic [37:0]            vary_q;
	logic signed [32:0]     delta_q;
	logic [31:0]            magd_q;
	logic [31:0]            magt_q;
	logic                   pos_q;
	logic [63:0]            prod_q;
	logic [63:0]            div_quo_q;
	logic [CB-1:0]          div_rem_q;
	logic [CB-1:0]          div_den_q;

	// memory read registers
	logic [CB-1:0]          rd_cnt_q;
	logic [31:0]            rd_mx_q;
	logic [31:0]            rd_my_q;
	logic [63:0]            rd_m2x_q;
	logic [63:0]            rd_m2y_q;
	logic                   rd_vld_q;
	logic [59:0]            box_rd_q;

	// output registers
	logic [1:0]             kind_q;
	logic [1:0]             slot_q;
	logic [1:0]             status_q;
	logic [19:0]            count_q;
	logic signed [30:0]     omx_q;
	logic signed [30:0]     omy_q;
	logic [37:0]            ovx_q;
	logic [37:0]            ovy_q;
	logic                   last_q;

	// memories
	logic [CB-1:0]          cnt_mem [NUM_ACC];
	logic [31:0]            mx_mem  [NUM_ACC];
	logic [31:0]            my_mem  [NUM_ACC];
	logic [63:0]            m2x_mem [NUM_ACC];
	logic [63:0]            m2y_mem [NUM_ACC];
	logic [59:0]            box_mem [BOX_N];

	// decode the incoming transaction
	logic           accept;
	logic [V_W-1:0] in_v;
	logic           in_v_ok;
	logic [RU_W-1:0] ru_in;
	logic           add_ok;
	logic           do_rst;
	logic           do_add;

	assign in_stall = (state_q != rrmv_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign in_v     = V_W'(var_index);
	assign in_v_ok  = (32'(var_index) < NUM_TRACKED);
	assign ru_in    = ru_q[in_v];
	assign add_ok   = (ru_in < RU_W'(MAX_REGIONS));
	assign do_rst   = accept && in_v_ok && (cmd == rrmv_pkg::CMD_RESET);
	assign do_add   = accept && in_v_ok && (cmd == rrmv_pkg::CMD_ADD);

	// addresses
	logic [ACC_W-1:0] cur_addr;
	logic [BOX_W-1:0] box_raddr;
	logic [BOX_W-1:0] add_box_addr;
	logic [ACC_W-1:0] add_acc_addr;

	assign cur_addr = is_reg_q ?
		ACC_W'(NUM_TRACKED + 32'(v_q) * MAX_REGIONS + 32'(j_q)) : ACC_W'(v_q);
	assign box_raddr    = BOX_W'(32'(v_q) * MAX_REGIONS + 32'(sc_q) - 1);
	assign add_box_addr = BOX_W'(32'(in_v) * MAX_REGIONS + 32'(ru_in));
	assign add_acc_addr = ACC_W'(NUM_TRACKED + 32'(in_v) * MAX_REGIONS + 32'(ru_in));

	// region hit test on the box just read
	logic hit;
	assign hit = (px_q >= $signed(box_rd_q[14:0]))  && (py_q >= $signed(box_rd_q[29:15])) &&
		(px_q <= $signed(box_rd_q[44:30])) && (py_q <= $signed(box_rd_q[59:45]));

	// accumulator as read, unwritten entries read as zero
	logic [CB-1:0] cnt_l;
	assign cnt_l = rd_vld_q ? rd_cnt_q : '0;

	// axis datapath
	logic signed [14:0] pv;
	logic signed [32:0] pv33;
	logic signed [31:0] mean_cur;
	logic signed [32:0] delta_c;
	logic [32:0]        delta_mag;
	logic signed [33:0] qs;
	logic signed [33:0] nm;
	logic signed [33:0] temp;
	logic [31:0]        magd;
	logic [31:0]        magt;
	logic               pos;
	logic [63:0]        inc;
	logic [64:0]        m2_sum;
	logic [63:0]        m2_cur;
	logic [63:0]        m2_new;

	assign pv        = ax_q ? py_q : px_q;
	assign pv33      = 33'($signed({pv, 16'h0000}));
	assign mean_cur  = ax_q ? my_q : mx_q;
	assign delta_c   = pv33 - 33'(mean_cur);
	assign delta_mag = delta_c[32] ? 33'(-delta_c) : 33'(delta_c);
	assign qs        = $signed({1'b0, div_quo_q[32:0]});
	assign nm        = 34'(mean_cur) + (delta_q[32] ? -qs : qs);
	assign temp      = 34'(pv33) - nm;
	assign magd      = delta_q[32] ? 32'(-delta_q) : 32'(delta_q);
	assign magt      = temp[33] ? 32'(-temp) : 32'(temp);
	assign pos       = (delta_q != '0) && (temp != '0) && (delta_q[32] == temp[33]);
	assign inc       = pos_q ? {24'h000000, prod_q[63:24]} : 64'h0;
	assign m2_cur    = ax_q ? m2y_q : m2x_q;
	assign m2_sum    = {1'b0, m2_cur} + {1'b0, inc};
	assign m2_new    = m2_sum[64] ? '1 : m2_sum[63:0];

	// shared divider
	logic          div_start;
	logic [63:0]   div_dividend;
	logic [CB-1:0] div_den;
	logic [CB:0]   div_shift;
	logic          div_ge;
	logic [CB:0]   div_diff;
	logic [37:0]   var_sat;

	assign div_start = (state_q == rrmv_pkg::ST_DLT) ||
		((state_q == rrmv_pkg::ST_VAR) && (cnt_q >= CB'(2)));
	assign div_dividend = (state_q == rrmv_pkg::ST_DLT) ? 64'(delta_mag) :
		(ax_q ? m2y_q : m2x_q);
	assign div_den   = (state_q == rrmv_pkg::ST_DLT) ? cnt_q : cnt_q - CB'(1);
	assign div_shift = {div_rem_q, div_quo_q[63]};
	assign div_ge    = (div_shift >= {1'b0, div_den_q});
	assign div_diff  = div_shift - {1'b0, div_den_q};
	assign var_sat   = (div_quo_q > 64'(rrmv_pkg::VAR_MAX)) ? rrmv_pkg::VAR_MAX :
		div_quo_q[37:0];

	// output handoff
	logic out_free;
	logic out_load;
	logic emit_last;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == rrmv_pkg::ST_EMIT) && out_free;
	assign emit_last = (wkind_q == rrmv_pkg::KIND_ACK) ? 1'b1 :
		(wkind_q == rrmv_pkg::KIND_VAR) ? (pend_q == '0) : ((pend_q >> 1) == '0);

	// next valid bits: clear on reset and add, set on write-back
	always_comb begin
		vld_d = acc_vld_q;
		for (int i = 0; i < NUM_ACC; i++) begin
			if (do_rst && ((i == 32'(in_v)) ||
				((i >= NUM_TRACKED + 32'(in_v) * MAX_REGIONS) &&
				(i < NUM_TRACKED + (32'(in_v) + 1) * MAX_REGIONS)))) begin
				vld_d[i] = 1'b0;
			end
			if (do_add && add_ok && (i == 32'(add_acc_addr))) begin
				vld_d[i] = 1'b0;
			end
			if ((state_q == rrmv_pkg::ST_WR) && (i == 32'(cur_addr))) begin
				vld_d[i] = 1'b1;
			end
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rrmv_pkg::ST_IDLE;
			ax_q        <= 1'b0;
			is_reg_q    <= 1'b0;
			j_q         <= '0;
			sc_q        <= '0;
			pend_q      <= '0;
			acc_vld_q   <= '0;
			out_valid_q <= 1'b0;
			div_busy_q  <= 1'b0;
			div_cnt_q   <= '0;
			for (int i = 0; i < NUM_TRACKED; i++) begin
				ru_q[i] <= '0;
			end
		end else begin
			acc_vld_q   <= vld_d;
			out_valid_q <= out_load || (out_valid_q && out_stall);

			// run the divider
			if (div_start) begin
				div_busy_q <= 1'b1;
				div_cnt_q  <= rrmv_pkg::DIV_STEPS;
			end else if (div_busy_q) begin
				div_cnt_q <= div_cnt_q - 7'd1;
				if (div_cnt_q == 7'd1) begin
					div_busy_q <= 1'b0;
				end
			end

			unique case (state_q)
				rrmv_pkg::ST_IDLE: begin
					if (accept && in_v_ok) begin
						case (cmd)
							rrmv_pkg::CMD_UPDATE: begin
								pend_q   <= '0;
								sc_q     <= ru_in;
								is_reg_q <= 1'b0;
								j_q      <= '0;
								state_q  <= (ru_in == '0) ? rrmv_pkg::ST_RD :
									rrmv_pkg::ST_SCRD;
							end
							rrmv_pkg::CMD_RESET: begin
								state_q <= rrmv_pkg::ST_EMIT;
							end
							rrmv_pkg::CMD_ADD: begin
								if (add_ok) begin
									ru_q[in_v] <= ru_in + RU_W'(1);
								end
								state_q <= rrmv_pkg::ST_EMIT;
							end
							default: begin
								state_q <= rrmv_pkg::ST_IDLE;
							end
						endcase
					end
				end
				rrmv_pkg::ST_SCRD: begin
					state_q <= rrmv_pkg::ST_SCCK;
				end
				rrmv_pkg::ST_SCCK: begin
					// scan from the top slot down, so slot zero lands in bit zero
					pend_q  <= (pend_q << 1) | MAX_REGIONS'(hit);
					sc_q    <= sc_q - RU_W'(1);
					state_q <= (sc_q == RU_W'(1)) ? rrmv_pkg::ST_RD : rrmv_pkg::ST_SCRD;
				end
				rrmv_pkg::ST_NEXT: begin
					if (pend_q[0]) begin
						is_reg_q <= 1'b1;
						state_q  <= rrmv_pkg::ST_RD;
					end else begin
						pend_q <= pend_q >> 1;
						j_q    <= j_q + RJ_W'(1);
					end
				end
				rrmv_pkg::ST_RD: begin
					state_q <= rrmv_pkg::ST_LOAD;
				end
				rrmv_pkg::ST_LOAD: begin
					ax_q <= 1'b0;
					if (&cnt_l) begin
						state_q <= rrmv_pkg::ST_VAR;
					end else if (cnt_l == '0) begin
						state_q <= rrmv_pkg::ST_WR;
					end else begin
						state_q <= rrmv_pkg::ST_DLT;
					end
				end
				rrmv_pkg::ST_DLT: begin
					state_q <= rrmv_pkg::ST_DIVW;
				end
				rrmv_pkg::ST_DIVW: begin
					if (!div_busy_q) begin
						state_q <= rrmv_pkg::ST_NM;
					end
				end
				rrmv_pkg::ST_NM: begin
					state_q <= rrmv_pkg::ST_MUL;
				end
				rrmv_pkg::ST_MUL: begin
					state_q <= rrmv_pkg::ST_M2;
				end
				rrmv_pkg::ST_M2: begin
					if (ax_q) begin
						state_q <= rrmv_pkg::ST_WR;
					end else begin
						ax_q    <= 1'b1;
						state_q <= rrmv_pkg::ST_DLT;
					end
				end
				rrmv_pkg::ST_WR: begin
					ax_q    <= 1'b0;
					state_q <= rrmv_pkg::ST_VAR;
				end
				rrmv_pkg::ST_VAR: begin
					state_q <= (cnt_q < CB'(2)) ? rrmv_pkg::ST_EMIT : rrmv_pkg::ST_VARW;
				end
				rrmv_pkg::ST_VARW: begin
					if (!div_busy_q) begin
						if (ax_q) begin
							state_q <= rrmv_pkg::ST_EMIT;
						end else begin
							ax_q    <= 1'b1;
							state_q <= rrmv_pkg::ST_VAR;
						end
					end
				end
				rrmv_pkg::ST_EMIT: begin
					if (out_free) begin
						case (wkind_q)
							rrmv_pkg::KIND_VAR: begin
								j_q     <= '0;
								state_q <= (pend_q == '0) ? rrmv_pkg::ST_IDLE :
									rrmv_pkg::ST_NEXT;
							end
							rrmv_pkg::KIND_REGION: begin
								pend_q  <= pend_q >> 1;
								j_q     <= j_q + RJ_W'(1);
								state_q <= ((pend_q >> 1) == '0) ? rrmv_pkg::ST_IDLE :
									rrmv_pkg::ST_NEXT;
							end
							default: begin
								state_q <= rrmv_pkg::ST_IDLE;
							end
						endcase
					end
				end
				default: begin
					state_q <= rrmv_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// working datapath registers
	always_ff @(posedge clk) begin
		// step the divider one quotient bit a cycle
		if (div_start) begin
			div_quo_q <= div_dividend;
			div_rem_q <= '0;
			div_den_q <= div_den;
		end else if (div_busy_q) begin
			div_quo_q <= {div_quo_q[62:0], div_ge};
			div_rem_q <= div_ge ? div_diff[CB-1:0] : div_shift[CB-1:0];
		end

		case (state_q)
			rrmv_pkg::ST_IDLE: begin
				if (accept) begin
					v_q     <= in_v;
					px_q    <= point_x;
					py_q    <= point_y;
					cnt_q   <= '0;
					mx_q    <= '0;
					my_q    <= '0;
					varx_q  <= '0;
					vary_q  <= '0;
					wkind_q <= rrmv_pkg::KIND_ACK;
					wstat_q <= rrmv_pkg::STAT_OK;
					wslot_q <= '0;
					if ((cmd == rrmv_pkg::CMD_ADD) && add_ok) begin
						wslot_q <= 2'(ru_in);
					end else if (cmd == rrmv_pkg::CMD_ADD) begin
						wstat_q <= rrmv_pkg::STAT_FULL;
					end
				end
			end
			rrmv_pkg::ST_LOAD: begin
				wkind_q <= is_reg_q ? rrmv_pkg::KIND_REGION : rrmv_pkg::KIND_VAR;
				wslot_q <= is_reg_q ? 2'(j_q) : 2'd0;
				mx_q    <= rd_vld_q ? $signed(rd_mx_q) : '0;
				my_q    <= rd_vld_q ? $signed(rd_my_q) : '0;
				m2x_q   <= rd_vld_q ? rd_m2x_q : '0;
				m2y_q   <= rd_vld_q ? rd_m2y_q : '0;
				if (&cnt_l) begin
					wstat_q <= rrmv_pkg::STAT_SAT;
					cnt_q   <= cnt_l;
				end else begin
					wstat_q <= rrmv_pkg::STAT_OK;
					cnt_q   <= cnt_l + CB'(1);
					if (cnt_l == '0) begin
						// first sample sets the mean
						mx_q  <= 32'($signed({px_q, 16'h0000}));
						my_q  <= 32'($signed({py_q, 16'h0000}));
						m2x_q <= '0;
						m2y_q <= '0;
					end
				end
			end
			rrmv_pkg::ST_DLT: begin
				delta_q <= delta_c;
			end
			rrmv_pkg::ST_NM: begin
				if (ax_q) begin
					my_q <= 32'(nm);
				end else begin
					mx_q <= 32'(nm);
				end
				magd_q <= magd;
				magt_q <= magt;
				pos_q  <= pos;
			end
			rrmv_pkg::ST_MUL: begin
				prod_q <= 64'(magd_q) * 64'(magt_q);
			end
			rrmv_pkg::ST_M2: begin
				if (ax_q) begin
					m2y_q <= m2_new;
				end else begin
					m2x_q <= m2_new;
				end
			end
			rrmv_pkg::ST_VAR: begin
				if (cnt_q < CB'(2)) begin
					varx_q <= '0;
					vary_q <= '0;
				end
			end
			rrmv_pkg::ST_VARW: begin
				if (!div_busy_q) begin
					if (ax_q) begin
						vary_q <= var_sat;
					end else begin
						varx_q <= var_sat;
					end
				end
			end
			default: begin
			end
		endcase

		// load the output register
		if (out_load) begin
			kind_q   <= wkind_q;
			slot_q   <= wslot_q;
			status_q <= wstat_q;
			count_q  <= 20'(cnt_q);
			omx_q    <= 31'(mx_q);
			omy_q    <= 31'(my_q);
			ovx_q    <= varx_q;
			ovy_q    <= vary_q;
			last_q   <= emit_last;
		end
	end

	// accumulator and box memories
	always_ff @(posedge clk) begin
		rd_cnt_q <= cnt_mem[cur_addr];
		rd_mx_q  <= mx_mem[cur_addr];
		rd_my_q  <= my_mem[cur_addr];
		rd_m2x_q <= m2x_mem[cur_addr];
		rd_m2y_q <= m2y_mem[cur_addr];
		rd_vld_q <= acc_vld_q[cur_addr];
		box_rd_q <= box_mem[box_raddr];
		if (state_q == rrmv_pkg::ST_WR) begin
			cnt_mem[cur_addr] <= cnt_q;
			mx_mem[cur_addr]  <= mx_q;
			my_mem[cur_addr]  <= my_q;
			m2x_mem[cur_addr] <= m2x_q;
			m2y_mem[cur_addr] <= m2y_q;
		end
		if (do_add && add_ok) begin
			box_mem[add_box_addr] <= {box_max_y, box_max_x, box_min_y, box_min_x};
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign region_slot  = slot_q;
	assign status       = status_q;
	assign sample_count = count_q;
	assign mean_x       = omx_q;
	assign mean_y       = omy_q;
	assign variance_x   = ovx_q;
	assign variance_y   = ovy_q;
	assign last         = last_q;

	// checks
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy_q)
		else $error("divider restarted while busy");

	a_wr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rrmv_pkg::ST_WR) |-> (cnt_q != '0))
		else $error("write-back with zero count");

	a_next_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rrmv_pkg::ST_NEXT) |-> (pend_q != '0))
		else $error("region search with no hit pending");

	a_load_hit: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == rrmv_pkg::ST_LOAD) && is_reg_q) |-> pend_q[0])
		else $error("region loaded without a hit");

endmodule

`default_nettype wire

@@ sim/region_running_mean_variance_unit_tb.sv @@
`timescale 1ns / 1ps

module region_running_mean_variance_unit_tb;

	localparam int NT = 4;
	localparam int MR = 4;
	localparam int NACC = NT + NT * MR;
	localparam int unsigned COUNT_FULL = 32'h000F_FFFF;
	localparam int CYCLE_LIMIT = 3_000_000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  slot;
		logic [1:0]  status;
		logic [19:0] count;
		logic [30:0] mean_x;
		logic [30:0] mean_y;
		logic [37:0] var_x;
		logic [37:0] var_y;
		logic        last;
	} stat_result_t;

	// Welford predictor over the variables and their regions, plus the queue of results owed
	class mean_var_scoreboard;
		int unsigned       cnt[NACC];
		int                mx[NACC];
		int                my[NACC];
		longint unsigned   m2x[NACC];
		longint unsigned   m2y[NACC];
		int                box[NT * MR][4];
		int unsigned       used[NT];
		stat_result_t      owed_q[$];
		int                errors;

		function void clear_acc(int a);
			cnt[a] = 0;
			mx[a] = 0;
			my[a] = 0;
			m2x[a] = 0;
			m2y[a] = 0;
		endfunction

		function void reset_all();
			for (int a = 0; a < NACC; a++) clear_acc(a);
			for (int v = 0; v < NT; v++) used[v] = 0;
			owed_q.delete();
			errors = 0;
		endfunction

		function void axis_step(inout int mean, inout longint unsigned m2, input int p,
				input int unsigned n);
			longint pv, delta, nm, prod;
			longint unsigned inc;
			pv = longint'(p) * 65536;
			if (n == 1) begin
				mean = int'(pv);
				m2 = 0;
				return;
			end
			delta = pv - longint'(mean);
			nm = longint'(mean) + delta / longint'(n);
			prod = delta * (pv - nm);
			inc = (prod > 0) ? ($unsigned(prod) >> 24) : 64'd0;
			mean = int'(nm);
			m2 = (m2 > ~64'd0 - inc) ? ~64'd0 : m2 + inc;
		endfunction

		function logic [37:0] variance(longint unsigned m2, int unsigned n);
			longint unsigned q;
			if (n < 2) return '0;
			q = m2 / longint'(n - 1);
			return (q > longint'(rrmv_pkg::VAR_MAX)) ? rrmv_pkg::VAR_MAX : q[37:0];
		endfunction

		function logic [1:0] acc_update(int a, int px, int py);
			if (cnt[a] >= COUNT_FULL) return rrmv_pkg::STAT_SAT;
			cnt[a]++;
			axis_step(mx[a], m2x[a], px, cnt[a]);
			axis_step(my[a], m2y[a], py, cnt[a]);
			return rrmv_pkg::STAT_OK;
		endfunction

		function void owe(logic [1:0] kind, logic [1:0] slot, logic [1:0] st, int a);
			stat_result_t r;
			r = '0;
			r.kind = kind;
			r.slot = slot;
			r.status = st;
			if (a >= 0) begin
				r.count = cnt[a][19:0];
				r.mean_x = mx[a][30:0];
				r.mean_y = my[a][30:0];
				r.var_x = variance(m2x[a], cnt[a]);
				r.var_y = variance(m2y[a], cnt[a]);
			end
			owed_q.push_back(r);
		endfunction

		// note an accepted transaction and queue the results it causes
		function void note_input(logic [1:0] c, logic [1:0] v, int px, int py,
				int bx0, int by0, int bx1, int by1);
			int rb, b;
			logic [1:0] st;
			if (int'(v) >= NT || c == rrmv_pkg::CMD_NOP) return;
			rb = NT + int'(v) * MR;
			case (c)
				rrmv_pkg::CMD_UPDATE: begin
					st = acc_update(int'(v), px, py);
					owe(rrmv_pkg::KIND_VAR, 2'd0, st, int'(v));
					for (int j = 0; j < int'(used[v]); j++) begin
						b = int'(v) * MR + j;
						if (px >= box[b][0] && py >= box[b][1] && px <= box[b][2] &&
								py <= box[b][3]) begin
							st = acc_update(rb + j, px, py);
							owe(rrmv_pkg::KIND_REGION, j[1:0], st, rb + j);
						end
					end
				end
				rrmv_pkg::CMD_RESET: begin
					clear_acc(int'(v));
					for (int j = 0; j < MR; j++) clear_acc(rb + j);
					owe(rrmv_pkg::KIND_ACK, 2'd0, rrmv_pkg::STAT_OK, -1);
				end
				default: begin
					if (used[v] >= MR) begin
						owe(rrmv_pkg::KIND_ACK, 2'd0, rrmv_pkg::STAT_FULL, -1);
					end else begin
						b = int'(v) * MR + int'(used[v]);
						box[b][0] = bx0;
						box[b][1] = by0;
						box[b][2] = bx1;
						box[b][3] = by1;
						clear_acc(rb + int'(used[v]));
						owe(rrmv_pkg::KIND_ACK, used[v][1:0], rrmv_pkg::STAT_OK, -1);
						used[v]++;
					end
				end
			endcase
			owed_q[owed_q.size() - 1].last = 1'b1;
		endfunction

		task report_mismatch(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(stat_result_t got);
			stat_result_t want;
			if (owed_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result %p", got));
				return;
			end
			want = owed_q.pop_front();
			if (got !== want)
				report_mismatch($sformatf("got %p want %p", got, want));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [1:0] cmd, var_index;
	logic signed [14:0] point_x, point_y, box_min_x, box_min_y, box_max_x, box_max_y;
	logic [1:0] kind, region_slot, status;
	logic [19:0] sample_count;
	logic signed [30:0] mean_x, mean_y;
	logic [37:0] variance_x, variance_y;
	logic last;

	mean_var_scoreboard sb;
	int tx_idle_pct;
	int rx_idle_pct;
	int cycles;

	region_running_mean_variance_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .var_index(var_index),
		.point_x(point_x), .point_y(point_y),
		.box_min_x(box_min_x), .box_min_y(box_min_y),
		.box_max_x(box_max_x), .box_max_y(box_max_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .region_slot(region_slot), .status(status),
		.sample_count(sample_count), .mean_x(mean_x), .mean_y(mean_y),
		.variance_x(variance_x), .variance_y(variance_y), .last(last)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		cmd = '0;
		var_index = '0;
		point_x = '0;
		point_y = '0;
		box_min_x = '0;
		box_min_y = '0;
		box_max_x = '0;
		box_max_y = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		cycles = 0;
		sb = new();
		sb.reset_all();
	end

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// stall the result side at random
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// check each result transaction against the oldest owed one
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({kind, region_slot, status, sample_count, mean_x, mean_y,
				variance_x, variance_y, last});
	end

	// abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// drive one transaction and hold it until accepted
	task send(logic [1:0] c, logic [1:0] v, int px, int py, int bx0, int by0, int bx1,
			int by1);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		var_index <= v;
		point_x <= px[14:0];
		point_y <= py[14:0];
		box_min_x <= bx0[14:0];
		box_min_y <= by0[14:0];
		box_max_x <= bx1[14:0];
		box_max_y <= by1[14:0];
		do @(posedge clk); while (in_stall);
		sb.note_input(c, v, px, py, bx0, by0, bx1, by1);
	endtask

	function int rand_full();
		return int'($urandom_range(32767)) - 16384;
	endfunction

	function int rand_near();
		return int'($urandom_range(400)) - 200;
	endfunction

	task random_item();
		int r, bx, by;
		logic [1:0] v;
		r = int'($urandom_range(99));
		v = 2'($urandom_range(3));
		if (r < 80) begin
			if ($urandom_range(9) < 7)
				send(rrmv_pkg::CMD_UPDATE, v, rand_near(), rand_near(), rand_full(),
					rand_full(), rand_full(), rand_full());
			else
				send(rrmv_pkg::CMD_UPDATE, v, rand_full(), rand_full(), rand_full(),
					rand_full(), rand_full(), rand_full());
		end else if (r < 92) begin
			if ($urandom_range(4) == 0) begin
				send(rrmv_pkg::CMD_ADD, v, rand_full(), rand_full(), rand_full(), rand_full(),
					rand_full(), rand_full());
			end else begin
				bx = rand_near();
				by = rand_near();
				send(rrmv_pkg::CMD_ADD, v, rand_full(), rand_full(), bx, by,
					bx + int'($urandom_range(250)), by + int'($urandom_range(250)));
			end
		end else if (r < 97) begin
			send(rrmv_pkg::CMD_RESET, v, rand_full(), rand_full(), rand_full(), rand_full(),
				rand_full(), rand_full());
		end else begin
			send(rrmv_pkg::CMD_NOP, v, rand_full(), rand_full(), rand_full(), rand_full(),
				rand_full(), rand_full());
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// build regions on variable 0: full range, small, inverted, corner; then overflow
		send(rrmv_pkg::CMD_ADD, 2'd0, 0, 0, -16384, -16384, 16383, 16383);
		send(rrmv_pkg::CMD_ADD, 2'd0, 0, 0, 0, 0, 100, 100);
		send(rrmv_pkg::CMD_ADD, 2'd0, 0, 0, 10, 10, -10, -10);
		send(rrmv_pkg::CMD_ADD, 2'd0, 0, 0, -100, -100, 0, 0);
		send(rrmv_pkg::CMD_ADD, 2'd0, 0, 0, 1, 2, 3, 4);
		// extremes and box edges
		send(rrmv_pkg::CMD_UPDATE, 2'd0, -16384, -16384, 0, 0, 0, 0);
		send(rrmv_pkg::CMD_UPDATE, 2'd0, 16383, 16383, 0, 0, 0, 0);
		send(rrmv_pkg::CMD_UPDATE, 2'd0, 0, 0, 0, 0, 0, 0);
		send(rrmv_pkg::CMD_UPDATE, 2'd0, 100, 0, 0, 0, 0, 0);
		send(rrmv_pkg::CMD_UPDATE, 2'd0, -16384, 16383, 0, 0, 0, 0);
		send(rrmv_pkg::CMD_UPDATE, 2'd0, 50, 50, 0, 0, 0, 0);
		send(rrmv_pkg::CMD_UPDATE, 2'd0, -100, -1, 0, 0, 0, 0);
		send(rrmv_pkg::CMD_UPDATE, 2'd1, 5, -5, 0, 0, 0, 0);
		send(rrmv_pkg::CMD_UPDATE, 2'd1, -7, 9, 0, 0, 0, 0);
		// unknown command is dropped
		send(rrmv_pkg::CMD_NOP, 2'd0, 1, 1, 0, 0, 0, 0);
		// clear variable 0, boxes stay
		send(rrmv_pkg::CMD_RESET, 2'd0, 0, 0, 0, 0, 0, 0);
		send(rrmv_pkg::CMD_UPDATE, 2'd0, 0, 0, 0, 0, 0, 0);
		send(rrmv_pkg::CMD_ADD, 2'd3, 0, 0, -50, -50, 50, 50);
		send(rrmv_pkg::CMD_UPDATE, 2'd3, 20, -20, 0, 0, 0, 0);
		send(rrmv_pkg::CMD_UPDATE, 2'd3, 60, 0, 0, 0, 0, 0);

		tx_idle_pct = 31;
		rx_idle_pct = 65;
		repeat (150) random_item();
		tx_idle_pct = 65;
		rx_idle_pct = 31;
		repeat (150) random_item();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (150) random_item();
		in_valid <= 1'b0;

		// drain
		while (sb.owed_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
